// ===== src/bgm_pkg.sv =====
// Shared constants and types for the battery gauge monitor.
`default_nettype none

package bgm_pkg;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 13;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Ring depth default.
    localparam int DEFAULT_WINDOW = 8;

    // Shared divider: dividend width and step counter width.
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = 5;

    // Converter scaling: full-scale code maps to full-scale pin voltage.
    localparam int RAW_FULL_MV   = 3300;
    localparam int RAW_FULL_CODE = 4095;

    // Percent scale.
    localparam int PCT_FULL = 100;

    // Reset values of the configuration registers and the gauge state.
    localparam logic [MV_W-1:0]  RST_EMPTY_MV  = MV_W'(3300);
    localparam logic [MV_W-1:0]  RST_FULL_MV   = MV_W'(4200);
    localparam logic [PCT_W-1:0] RST_LOW_THR   = PCT_W'(20);
    localparam logic [PCT_W-1:0] RST_REARM     = PCT_W'(5);
    localparam logic [MV_W-1:0]  RST_AVG_MV    = MV_W'(4200);
    localparam logic [PCT_W-1:0] RST_LEVEL_PCT = PCT_W'(100);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMPTY_MV     = 2'd0,
        REG_FULL_MV      = 2'd1,
        REG_LOW_THR_PCT  = 2'd2,
        REG_REARM_PCT    = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/battery_gauge_monitor_top.sv =====
// Top level of the battery gauge monitor: sequencer, shared divider and output stage.
//
//   Channel   Direction  Handshake            Item contents
//   -------   ---------  -------------------  ------------------------------------------
//   in        input      in_valid / in_ready  sample, sample_is_raw, sample_valid,
//                                             chrg_pin, stdby_pin
//   out       output     out_valid/out_ready  avg_mv, level_pct, charging,
//                                             charge_complete, charging_changed, low_alert
//   cfg       input      cfg_we (no wait)     cfg_index, cfg_data
//
// The shared restoring divider produces one quotient bit per cycle and runs DIV_W = 24
// steps for each use: once for a raw converter code, always once for the mean, and once
// more, plus a ST_LVL_DONE state to take the quotient, when the level falls between
// the two limits. Summing the ring takes one read per filled entry through the
// registered read port. in_ready returns in the same cycle as the result is offered.
// Reset is asynchronous and active low; it loads the register defaults and the gauge
// state. The ring needs no clearing pass, since only written entries are ever summed.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so a new item is taken while out_ready is low, and the sequencer
// only holds in its last state when the previous result has not yet been taken.
`default_nettype none

module battery_gauge_monitor_top
    import bgm_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SAMPLE_W-1:0]  sample,
    input  wire logic                 sample_is_raw,
    input  wire logic                 sample_valid,
    input  wire logic                 chrg_pin,
    input  wire logic                 stdby_pin,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [MV_W-1:0]      avg_mv,
    output logic      [PCT_W-1:0]     level_pct,
    output logic                      charging,
    output logic                      charge_complete,
    output logic                      charging_changed,
    output logic                      low_alert,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MV_W-1:0]      cfg_data
);

    // Ring indexing and sum widths follow the window depth.
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(WINDOW * (1 << MV_W));

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DIV_RAW = 9'b000000010,
        ST_WRITE   = 9'b000000100,
        ST_SUM     = 9'b000001000,
        ST_DIV_AVG = 9'b000010000,
        ST_LEVEL   = 9'b000100000,
        ST_DIV_LVL = 9'b001000000,
        ST_LVL_DONE = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [MV_W-1:0]  empty_mv_reg, empty_mv_next;
    logic [MV_W-1:0]  full_mv_reg, full_mv_next;
    logic [PCT_W-1:0] low_thr_reg, low_thr_next;
    logic [PCT_W-1:0] rearm_reg, rearm_next;

    // Latched item fields.
    logic [MV_W-1:0]  entry_reg, entry_next;
    logic             use_quo_reg, use_quo_next;
    logic             chrg_reg, chrg_next;
    logic             stdby_reg, stdby_next;

    // Gauge state.
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [MV_W-1:0]  avg_reg, avg_next;
    logic [PCT_W-1:0] level_reg, level_next;
    logic             charging_flag_reg, charging_flag_next;
    logic             complete_flag_reg, complete_flag_next;
    logic             low_warned_reg, low_warned_next;

    // Ring summation.
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    // Shared restoring divider.
    logic [MV_W-1:0]      div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [MV_W-1:0]      div_dvs_reg, div_dvs_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Output stage.
    logic             out_valid_reg, out_valid_next;
    logic [MV_W-1:0]  o_avg_reg, o_avg_next;
    logic [PCT_W-1:0] o_level_reg, o_level_next;
    logic             o_chg_reg, o_chg_next;
    logic             o_cmp_reg, o_cmp_next;
    logic             o_chgd_reg, o_chgd_next;
    logic             o_alert_reg, o_alert_next;

    // Ring memory port.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [MV_W-1:0]  ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [MV_W-1:0]  ram_rdata;

    // Divider step and level datapath.
    logic [MV_W:0]    div_rem_sh;
    logic             div_ge;
    logic             div_last;
    logic [MV_W-1:0]  avg_new;
    logic [MV_W-1:0]  lvl_diff;
    logic [MV_W-1:0]  lvl_span;
    logic             rd_issue;
    logic [PCT_W:0]   rearm_level;
    logic             charging_now;

    bgm_ram #(
        .WIDTH (MV_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    assign div_rem_sh = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge     = div_rem_sh >= {1'b0, div_dvs_reg};
    assign div_last   = div_cnt_reg == DIV_CNT_W'(DIV_W - 1);

    assign avg_new  = div_quo_reg[MV_W-1:0];
    assign lvl_diff = avg_new - empty_mv_reg;
    assign lvl_span = full_mv_reg - empty_mv_reg;
    assign rd_issue = rd_cnt_reg < fill_reg;

    // Re-arm level is formed one bit wider so threshold plus margin never wraps.
    assign rearm_level  = {1'b0, low_thr_reg} + {1'b0, rearm_reg};
    assign charging_now = !chrg_reg;

    always_comb
    begin
        state_next         = state_reg;
        empty_mv_next      = empty_mv_reg;
        full_mv_next       = full_mv_reg;
        low_thr_next       = low_thr_reg;
        rearm_next         = rearm_reg;
        entry_next         = entry_reg;
        use_quo_next       = use_quo_reg;
        chrg_next          = chrg_reg;
        stdby_next         = stdby_reg;
        widx_next          = widx_reg;
        fill_next          = fill_reg;
        avg_next           = avg_reg;
        level_next         = level_reg;
        charging_flag_next = charging_flag_reg;
        complete_flag_next = complete_flag_reg;
        low_warned_next    = low_warned_reg;
        rd_cnt_next        = rd_cnt_reg;
        rd_pend_next       = rd_pend_reg;
        sum_next           = sum_reg;
        div_rem_next       = div_rem_reg;
        div_quo_next       = div_quo_reg;
        div_dvs_next       = div_dvs_reg;
        div_cnt_next       = div_cnt_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        o_avg_next         = o_avg_reg;
        o_level_next       = o_level_reg;
        o_chg_next         = o_chg_reg;
        o_cmp_next         = o_cmp_reg;
        o_chgd_next        = o_chgd_reg;
        o_alert_next       = o_alert_reg;
        ram_we             = 1'b0;
        ram_waddr          = widx_reg;
        ram_wdata          = use_quo_reg ? {div_quo_reg[MV_W-2:0], 1'b0} : entry_reg;
        ram_re             = 1'b0;
        ram_raddr          = rd_cnt_reg[IDX_W-1:0];

        // The user makes configuration writes only while idle (not enforced); pct registers keep their low bits.
        if (cfg_we)
        begin
            case (cfg_index)
                REG_EMPTY_MV:    empty_mv_next = cfg_data;
                REG_FULL_MV:     full_mv_next  = cfg_data;
                REG_LOW_THR_PCT: low_thr_next  = cfg_data[PCT_W-1:0];
                REG_REARM_PCT:   rearm_next    = cfg_data[PCT_W-1:0];
                default:         ;
            endcase
        end

        // Every division state runs the shared divider one step per cycle.
        if ((state_reg == ST_DIV_RAW) || (state_reg == ST_DIV_AVG)
            || (state_reg == ST_DIV_LVL))
        begin
            div_rem_next = div_ge ? MV_W'(div_rem_sh - {1'b0, div_dvs_reg})
                                  : div_rem_sh[MV_W-1:0];
            div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    chrg_next    = chrg_pin;
                    stdby_next   = stdby_pin;
                    use_quo_next = sample_valid && sample_is_raw;
                    // A failed read pushes the current average as it is.
                    entry_next   = sample_valid ? {sample, 1'b0} : avg_reg;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    div_quo_next = DIV_W'(sample) * DIV_W'(RAW_FULL_MV);
                    div_dvs_next = MV_W'(RAW_FULL_CODE);
                    state_next   = (sample_valid && sample_is_raw) ? ST_DIV_RAW : ST_WRITE;
                end
            end

            ST_DIV_RAW:
            begin
                if (div_last)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                ram_we       = 1'b1;
                widx_next    = (widx_reg == IDX_W'(WINDOW - 1)) ? '0 : widx_reg + 1'b1;
                fill_next    = (fill_reg < CNT_W'(WINDOW)) ? fill_reg + 1'b1 : fill_reg;
                rd_cnt_next  = '0;
                rd_pend_next = 1'b0;
                sum_next     = '0;
                state_next   = ST_SUM;
            end

            ST_SUM:
            begin
                ram_re       = rd_issue;
                rd_pend_next = rd_issue;
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                end
                if (!rd_issue && !rd_pend_reg)
                begin
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    div_quo_next = DIV_W'(sum_reg);
                    div_dvs_next = MV_W'(fill_reg);
                    state_next   = ST_DIV_AVG;
                end
            end

            ST_DIV_AVG:
            begin
                if (div_last)
                begin
                    state_next = ST_LEVEL;
                end
            end

            ST_LEVEL:
            begin
                avg_next = avg_new;
                if (avg_new <= empty_mv_reg)
                begin
                    level_next = '0;
                    state_next = ST_FINISH;
                end
                else if (avg_new >= full_mv_reg)
                begin
                    level_next = PCT_W'(PCT_FULL);
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    div_quo_next = DIV_W'(lvl_diff) * DIV_W'(PCT_FULL);
                    div_dvs_next = lvl_span;
                    state_next   = ST_DIV_LVL;
                end
            end

            ST_DIV_LVL:
            begin
                if (div_last)
                begin
                    state_next = ST_LVL_DONE;
                end
            end

            ST_LVL_DONE:
            begin
                level_next = div_quo_reg[PCT_W-1:0];
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    charging_flag_next = charging_now;
                    complete_flag_next = !stdby_reg;
                    o_avg_next         = avg_reg;
                    o_level_next       = level_reg;
                    o_chg_next         = charging_now;
                    o_cmp_next         = !stdby_reg;
                    o_chgd_next        = charging_now != charging_flag_reg;
                    o_alert_next       = 1'b0;
                    if (level_reg <= low_thr_reg)
                    begin
                        if (!low_warned_reg)
                        begin
                            low_warned_next = 1'b1;
                            o_alert_next    = 1'b1;
                        end
                    end
                    else if ({1'b0, level_reg} > rearm_level)
                    begin
                        low_warned_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            empty_mv_reg      <= RST_EMPTY_MV;
            full_mv_reg       <= RST_FULL_MV;
            low_thr_reg       <= RST_LOW_THR;
            rearm_reg         <= RST_REARM;
            entry_reg         <= '0;
            use_quo_reg       <= 1'b0;
            chrg_reg          <= 1'b1;
            stdby_reg         <= 1'b1;
            widx_reg          <= '0;
            fill_reg          <= '0;
            avg_reg           <= RST_AVG_MV;
            level_reg         <= RST_LEVEL_PCT;
            charging_flag_reg <= 1'b0;
            complete_flag_reg <= 1'b0;
            low_warned_reg    <= 1'b0;
            rd_cnt_reg        <= '0;
            rd_pend_reg       <= 1'b0;
            sum_reg           <= '0;
            div_rem_reg       <= '0;
            div_quo_reg       <= '0;
            div_dvs_reg       <= MV_W'(RAW_FULL_CODE);
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            o_avg_reg         <= '0;
            o_level_reg       <= '0;
            o_chg_reg         <= 1'b0;
            o_cmp_reg         <= 1'b0;
            o_chgd_reg        <= 1'b0;
            o_alert_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            empty_mv_reg      <= empty_mv_next;
            full_mv_reg       <= full_mv_next;
            low_thr_reg       <= low_thr_next;
            rearm_reg         <= rearm_next;
            entry_reg         <= entry_next;
            use_quo_reg       <= use_quo_next;
            chrg_reg          <= chrg_next;
            stdby_reg         <= stdby_next;
            widx_reg          <= widx_next;
            fill_reg          <= fill_next;
            avg_reg           <= avg_next;
            level_reg         <= level_next;
            charging_flag_reg <= charging_flag_next;
            complete_flag_reg <= complete_flag_next;
            low_warned_reg    <= low_warned_next;
            rd_cnt_reg        <= rd_cnt_next;
            rd_pend_reg       <= rd_pend_next;
            sum_reg           <= sum_next;
            div_rem_reg       <= div_rem_next;
            div_quo_reg       <= div_quo_next;
            div_dvs_reg       <= div_dvs_next;
            div_cnt_reg       <= div_cnt_next;
            out_valid_reg     <= out_valid_next;
            o_avg_reg         <= o_avg_next;
            o_level_reg       <= o_level_next;
            o_chg_reg         <= o_chg_next;
            o_cmp_reg         <= o_cmp_next;
            o_chgd_reg        <= o_chgd_next;
            o_alert_reg       <= o_alert_next;
        end
    end

    assign in_ready         = state_reg == ST_IDLE;
    assign out_valid        = out_valid_reg;
    assign avg_mv           = o_avg_reg;
    assign level_pct        = o_level_reg;
    assign charging         = o_chg_reg;
    assign charge_complete  = o_cmp_reg;
    assign charging_changed = o_chgd_reg;
    assign low_alert        = o_alert_reg;

`ifndef SYNTHESIS
    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count exceeds ring depth");

    // The divider remainder stays below its divisor at every step.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RAW || state_reg == ST_DIV_AVG || state_reg == ST_DIV_LVL)
        |-> (div_rem_reg < div_dvs_reg))
        else $error("divider remainder not below divisor");

    // A level quotient taken from the divider is always below full scale.
    a_lvl_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LVL_DONE) |-> (div_quo_reg < DIV_W'(PCT_FULL)))
        else $error("level quotient out of range");

    // A pending alert result always agrees with the armed state.
    a_alert_warned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_alert_reg) |-> low_warned_reg)
        else $error("low alert pending while alert is re-armed");

    // Summation ends with every filled entry read.
    a_sum_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && state_next == ST_DIV_AVG) |-> (rd_cnt_reg == fill_reg))
        else $error("ring sum finished early");
`endif

endmodule

`default_nettype wire

// ===== src/bgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bgm_ram
    import bgm_pkg::*;
#(
    parameter int WIDTH = MV_W,
    parameter int DEPTH = DEFAULT_WINDOW,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== verif/battery_gauge_monitor_checker.sv =====
// Checker for the battery gauge monitor: tracks the gauge state and compares every result item.
module battery_gauge_monitor_checker
    import bgm_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [SAMPLE_W-1:0]  sample,
    input  wire logic                 sample_is_raw,
    input  wire logic                 sample_valid,
    input  wire logic                 chrg_pin,
    input  wire logic                 stdby_pin,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [MV_W-1:0]      avg_mv,
    input  wire logic [PCT_W-1:0]     level_pct,
    input  wire logic                 charging,
    input  wire logic                 charge_complete,
    input  wire logic                 charging_changed,
    input  wire logic                 low_alert,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MV_W-1:0]      cfg_data,
    output int                        fail_count,
    output int                        pending_results,
    output int                        results_checked,
    output int                        alerts_seen
);

    typedef struct packed {
        logic [MV_W-1:0]  avg;
        logic [PCT_W-1:0] level;
        logic             chg;
        logic             done;
        logic             changed;
        logic             alert;
    } gauge_result_t;

    logic [MV_W-1:0]  empty_lim;
    logic [MV_W-1:0]  full_lim;
    logic [PCT_W-1:0] low_thr;
    logic [PCT_W-1:0] rearm_margin;

    logic [MV_W-1:0]  ring [WINDOW];
    int unsigned      wr_ptr;
    int unsigned      filled;
    logic [MV_W-1:0]  avg_now;
    logic             charging_now;
    logic             warned;

    gauge_result_t    expected_polls [$];
    gauge_result_t    want;

    function automatic logic [PCT_W-1:0] level_of(input logic [MV_W-1:0] mv);
        if (mv <= empty_lim)
            return '0;
        if (mv >= full_lim)
            return PCT_W'(PCT_FULL);
        return PCT_W'((int'(mv - empty_lim) * PCT_FULL) / int'(full_lim - empty_lim));
    endfunction

    // Applies one accepted poll to the tracked state and queues the result it must produce.
    task automatic predict_poll();
        int unsigned     pin_mv;
        int unsigned     total;
        logic [MV_W-1:0] entry;
        gauge_result_t   r;
        if (sample_valid)
        begin
            pin_mv = sample_is_raw ? (int'(sample) * RAW_FULL_MV) / RAW_FULL_CODE
                                   : int'(sample);
            entry = MV_W'(pin_mv * 2);
        end
        else
            entry = avg_now;
        ring[wr_ptr] = entry;
        wr_ptr = (wr_ptr + 1) % WINDOW;
        if (filled < WINDOW)
            filled++;
        total = 0;
        for (int i = 0; i < filled; i++)
            total += ring[i];
        avg_now = MV_W'(total / filled);
        r.avg = avg_now;
        r.level = level_of(avg_now);
        r.changed = (!chrg_pin) != charging_now;
        charging_now = !chrg_pin;
        r.chg = charging_now;
        r.done = !stdby_pin;
        r.alert = 1'b0;
        if (r.level <= low_thr)
        begin
            if (!warned)
            begin
                warned = 1'b1;
                r.alert = 1'b1;
            end
        end
        else if (int'(r.level) > int'(low_thr) + int'(rearm_margin))
            warned = 1'b0;
        expected_polls.push_back(r);
    endtask

    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_lim = RST_EMPTY_MV;
            full_lim = RST_FULL_MV;
            low_thr = RST_LOW_THR;
            rearm_margin = RST_REARM;
            wr_ptr = 0;
            filled = 0;
            avg_now = RST_AVG_MV;
            charging_now = 1'b0;
            warned = 1'b0;
            expected_polls.delete();
            fail_count = 0;
            results_checked = 0;
            alerts_seen = 0;
        end
        else
        begin
            // Results go first, so an item taken at the same edge never matches itself.
            if (out_valid && out_ready)
            begin
                if (expected_polls.size() == 0)
                begin
                    $display("%0t: result item with none expected, expected nothing, actual avg_mv %0d level_pct %0d",
                             $time, avg_mv, level_pct);
                    fail_count++;
                end
                else
                begin
                    want = expected_polls.pop_front();
                    results_checked++;
                    check_field("avg_mv", want.avg, avg_mv);
                    check_field("level_pct", want.level, level_pct);
                    check_field("charging", want.chg, charging);
                    check_field("charge_complete", want.done, charge_complete);
                    check_field("charging_changed", want.changed, charging_changed);
                    check_field("low_alert", want.alert, low_alert);
                end
                if (low_alert)
                    alerts_seen++;
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_EMPTY_MV:    empty_lim = cfg_data;
                    REG_FULL_MV:     full_lim = cfg_data;
                    REG_LOW_THR_PCT: low_thr = cfg_data[PCT_W-1:0];
                    REG_REARM_PCT:   rearm_margin = cfg_data[PCT_W-1:0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                predict_poll();
        end
        pending_results = expected_polls.size();
    end

endmodule

// ===== verif/battery_gauge_monitor_top_tb.sv =====
// Testbench top for the battery gauge monitor: clock, reset, stimulus, backpressure and verdict.
module battery_gauge_monitor_top_tb;
    import bgm_pkg::*;

    // About 1500 polls, with idle gaps on both sides and one long output stall, stay far
    // below this cycle limit.
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 240;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 120;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  sample;
    logic                 sample_is_raw;
    logic                 sample_valid;
    logic                 chrg_pin;
    logic                 stdby_pin;
    logic                 out_valid;
    logic                 out_ready;
    logic [MV_W-1:0]      avg_mv;
    logic [PCT_W-1:0]     level_pct;
    logic                 charging;
    logic                 charge_complete;
    logic                 charging_changed;
    logic                 low_alert;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MV_W-1:0]      cfg_data;

    int fail_count;
    int pending_results;
    int results_checked;
    int alerts_seen;

    int cycle_count = 0;
    int items_sent = 0;

    // Flags shared between the sender and the receiver. A tight stretch means no idle
    // cycles on that side; the hold request asks the receiver for one long stall.
    bit tight_in = 1'b0;
    bit tight_out = 1'b0;
    bit hold_out_req = 1'b0;

    // Simulated battery that slowly discharges and recharges, so that the level sweeps
    // through the whole map and the low alert fires and re-arms again and again.
    int bat_mv = 4300;
    bit bat_rising = 1'b0;

    battery_gauge_monitor_top u_dut (.*);

    battery_gauge_monitor_checker #(.WINDOW(DEFAULT_WINDOW)) u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results);
            $display("battery_gauge_monitor_top verification failed");
            $finish;
        end
    end

    // Offers one poll item and withdraws it once it is taken. With no gap the next item
    // is raised at the same falling edge, so the block sees back-to-back items without
    // a dip in between.
    task automatic send_poll(input logic [SAMPLE_W-1:0] s, input bit raw, input bit ok,
                             input bit chrg, input bit stdby);
        int gap;
        gap = tight_in ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample = s;
        sample_is_raw = raw;
        sample_valid = ok;
        chrg_pin = chrg;
        stdby_pin = stdby;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
    endtask

    // Waits until every predicted result has come back; the block is idle after that.
    task automatic drain_results();
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [MV_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_limits(input logic [MV_W-1:0] e, input logic [MV_W-1:0] f,
                              input logic [MV_W-1:0] thr, input logic [MV_W-1:0] margin);
        write_reg(REG_EMPTY_MV, e);
        write_reg(REG_FULL_MV, f);
        write_reg(REG_LOW_THR_PCT, thr);
        write_reg(REG_REARM_PCT, margin);
    endtask

    // Most polls follow the simulated battery, sent either as a pin voltage or as the
    // matching raw converter code. The rest are failed reads and fully random samples,
    // and the charger pins now and then glitch away from what the battery suggests.
    task automatic random_poll();
        int              kind;
        int              pin;
        bit              raw;
        bit              ok;
        bit              chrg;
        bit              stdby;
        logic [SAMPLE_W-1:0] s;
        kind = $urandom_range(0, 99);
        if (bat_rising)
            bat_mv += $urandom_range(0, 40);
        else
            bat_mv -= $urandom_range(0, 40);
        if (bat_mv > 4350)
            bat_rising = 1'b0;
        if (bat_mv < 2900)
            bat_rising = 1'b1;
        pin = bat_mv / 2;
        raw = 1'($urandom_range(0, 1));
        ok = 1'b1;
        s = raw ? SAMPLE_W'(pin * RAW_FULL_CODE / RAW_FULL_MV) : SAMPLE_W'(pin);
        if (kind < 8)
        begin
            ok = 1'b0;
            s = SAMPLE_W'($urandom_range(0, 4095));
        end
        else if (kind < 20)
            s = SAMPLE_W'($urandom_range(0, 4095));
        // The pins are active low: charging pulls chrg_pin low, a full battery stdby_pin.
        chrg = !bat_rising;
        stdby = !(bat_rising && bat_mv > 4150);
        if ($urandom_range(0, 19) == 0)
            chrg = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 19) == 0)
            stdby = 1'($urandom_range(0, 1));
        send_poll(s, raw, ok, chrg, stdby);
    endtask

    // Receiver: draws a stall before each result, or takes the long stall when asked.
    // The long stall is counted here, so the sender keeps offering items meanwhile and
    // the block ends up holding a result and refusing further input.
    initial
    begin : receiver
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_out_req)
            begin
                hold = LONG_HOLD_CYCLES;
                hold_out_req = 1'b0;
            end
            else
                hold = tight_out ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [MV_W-1:0] e;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        sample_is_raw = 1'b0;
        sample_valid = 1'b0;
        chrg_pin = 1'b1;
        stdby_pin = 1'b1;
        cfg_we = 1'b0;
        cfg_index = REG_EMPTY_MV;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset limits. The first poll is a failed read, so the
        // ring starts with the reset average. Then the sample extremes in both encodings,
        // another failed read, and all four pin combinations with charging changes.
        send_poll(12'hAAA, 1'b1, 1'b0, 1'b1, 1'b1);
        send_poll(12'd4095, 1'b1, 1'b1, 1'b0, 1'b1);
        send_poll(12'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(12'd4095, 1'b0, 1'b1, 1'b0, 1'b0);
        send_poll(12'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(12'h555, 1'b0, 1'b0, 1'b0, 1'b1);
        send_poll(12'd2100, 1'b0, 1'b1, 1'b0, 1'b1);
        send_poll(12'd2100, 1'b1, 1'b1, 1'b1, 1'b1);
        // A run of 3000 mV readings drags the level to zero: the alert fires once only.
        repeat (8)
            send_poll(12'd1500, 1'b0, 1'b1, 1'b1, 1'b1);
        // A full window at 4300 mV lifts the level to the top and re-arms the alert.
        repeat (8)
            send_poll(12'd2150, 1'b0, 1'b1, 1'b0, 1'b0);

        // Random part, one limit setting per phase. Each change waits for an idle block.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: ;
                // Widest map, alert only at zero and re-armed by any level above it.
                1: set_limits(13'd0, 13'd8191, 13'd0, 13'd0);
                // Inverted limits, and a threshold above 100 written with junk in the
                // upper bits that the block must mask off: the alert fires only once.
                2: set_limits(13'd8191, 13'd0, 13'h1FFF, 13'h1FFF);
                // Equal limits never divide; the level is 0 or 100.
                3: set_limits(13'd4000, 13'd4000, 13'd100, 13'd0);
                default:
                begin
                    e = MV_W'($urandom_range(2800, 3700));
                    set_limits(e, e + 13'($urandom_range(200, 900)),
                               13'($urandom_range(5, 60)), 13'($urandom_range(0, 20)));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                begin
                    tight_in = ($urandom_range(0, 3) == 0);
                    tight_out = ($urandom_range(0, 3) == 0);
                end
                if (phase == 1 && n == 60)
                    hold_out_req = 1'b1;
                // The sender stops once here until every result is back.
                if (phase == 4 && n == 120)
                    drain_results();
                random_poll();
            end
        end
        in_valid = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d polls over %0d limit settings; %0d results checked, %0d low alerts.",
                 items_sent, RANDOM_PHASES, results_checked, alerts_seen);
        $display("Covered raw and mV samples, failed reads, pin changes, odd limits and a long stall.");
        if (fail_count == 0)
            $display("battery_gauge_monitor_top verification clean");
        else
            $display("battery_gauge_monitor_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bgm_pkg.sv
src/bgm_ram.sv
src/battery_gauge_monitor_top.sv
verif/battery_gauge_monitor_checker.sv
verif/battery_gauge_monitor_top_tb.sv
